// ===== rtl/tbk_pkg.sv =====
// Shared types and constants for the timer bank with auto-reload.
// Field widths, command and result codes, and the queued command item.
// No dependencies.
package tbk_pkg;

    localparam int DEF_NUM_SLOTS   = 16;
    localparam int DEF_COUNT_WIDTH = 24;

    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 4;
    localparam int SETTING_W = 24;
    localparam int TAG_W     = 16;
    localparam int KIND_W    = 4;

    // power of two: pointers wrap naturally
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REPEAT = 3'd4;

    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 4'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOCATED = 4'd2;
    localparam logic [KIND_W-1:0] KIND_FULL      = 4'd3;
    localparam logic [KIND_W-1:0] KIND_STARTED   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RUNNING   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_STOPPED   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NOT_ALLOC = 4'd7;
    localparam logic [KIND_W-1:0] KIND_MODE_SET  = 4'd8;

    typedef struct packed {
        logic [CMD_W-1:0]     op;
        logic [SLOT_W-1:0]    slot;
        logic [SETTING_W-1:0] setting;
        logic [TAG_W-1:0]     tag;
        logic                 rep;
    } cmd_item_t;

endpackage

// ===== rtl/tbk_front.sv =====
// Command front end: takes input transfers, drops unknown commands and
// queues the rest for the execution side. Depends on tbk_pkg.
module tbk_front
    import tbk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [SETTING_W-1:0] count_setting,
    input  logic [TAG_W-1:0]     tag,
    input  logic                 repeat_req,
    output logic                 q_valid,
    output cmd_item_t            q_item,
    input  logic                 q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_item_t        q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   fill_reg;
    logic [PTR_W:0]   fill_next;
    logic             cmd_known;
    logic             push;
    logic             pop;
    cmd_item_t        new_item;

    assign cmd_known = (cmd == CMD_TICK) || (cmd == CMD_ALLOC) || (cmd == CMD_START)
                    || (cmd == CMD_STOP) || (cmd == CMD_REPEAT);
    assign in_stall  = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall && cmd_known;
    assign q_valid   = (fill_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_item    = q_mem[rd_ptr_reg];

    always_comb
    begin
        new_item.op      = cmd;
        new_item.slot    = slot;
        new_item.setting = count_setting;
        new_item.tag     = tag;
        new_item.rep     = repeat_req;
        wr_ptr_next      = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next      = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next        = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/tbk_back.sv =====
// Execution side: slot flags, count/reload/tag memories, tick sweep
// sequencer and the result register. Depends on tbk_pkg.
module tbk_back
    import tbk_pkg::*;
#(
    parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_item_t         q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KIND_W-1:0] kind,
    output logic [SLOT_W-1:0] slot_out,
    output logic [TAG_W-1:0]  tag_out,
    output logic              last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_EVAL    = 3'd2;
    localparam logic [2:0] ST_FLUSH   = 3'd3;
    localparam logic [2:0] ST_ALLOC   = 3'd4;
    localparam logic [2:0] ST_SINGLE  = 3'd5;
    localparam logic [2:0] ST_STOP_RD = 3'd6;
    localparam logic [2:0] ST_STOP_WR = 3'd7;

    logic [COUNT_WIDTH-1:0] count_mem  [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] reload_mem [NUM_SLOTS];
    logic [TAG_W-1:0]       tag_mem    [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] rd_count_reg;
    logic [COUNT_WIDTH-1:0] rd_reload_reg;
    logic [TAG_W-1:0]       rd_tag_reg;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [TAG_W-1:0]     pend_tag_reg, pend_tag_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [NUM_SLOTS-1:0] running_reg, running_next;
    logic [NUM_SLOTS-1:0] repeat_reg, repeat_next;
    cmd_item_t            cur_item_reg, cur_item_next;
    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [TAG_W-1:0]     out_tag_reg;
    logic                 out_last_reg;

    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   cnt_we;
    logic [IDX_W-1:0]       cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic                   alloc_we;
    logic                   emit_en;
    logic [KIND_W-1:0]      emit_kind;
    logic [SLOT_W-1:0]      emit_slot;
    logic [TAG_W-1:0]       emit_tag;
    logic                   emit_last;
    logic                   advance;
    logic                   out_free;
    logic [IDX_W-1:0]       slot_idx;
    logic                   slot_ok;
    logic                   slot_run;
    logic [IDX_W-1:0]       free_idx;
    logic                   free_found;
    logic [COUNT_WIDTH-1:0] sat_count;

    assign out_free  = !out_valid_reg || !out_stall;
    assign slot_idx  = IDX_W'(cur_item_reg.slot);
    assign slot_ok   = (32'(cur_item_reg.slot) < 32'(NUM_SLOTS)) ? used_reg[slot_idx] : 1'b0;
    assign slot_run  = slot_ok ? running_reg[slot_idx] : 1'b0;
    assign sat_count = (|(cur_item_reg.setting >> COUNT_WIDTH)) ? '1
                     : COUNT_WIDTH'(cur_item_reg.setting);

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;
        used_next       = used_reg;
        running_next    = running_reg;
        repeat_next     = repeat_reg;
        cur_item_next   = cur_item_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = slot_idx;
        cnt_we          = 1'b0;
        cnt_waddr       = slot_idx;
        cnt_wdata       = rd_reload_reg;
        alloc_we        = 1'b0;
        emit_en         = 1'b0;
        emit_kind       = KIND_TICK_DONE;
        emit_slot       = '0;
        emit_tag        = '0;
        emit_last       = 1'b1;
        advance         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    cur_item_next   = q_item;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    unique case (q_item.op)
                        CMD_TICK:  state_next = ST_SCAN;
                        CMD_ALLOC: state_next = ST_ALLOC;
                        CMD_STOP:  state_next = ST_STOP_RD;
                        default:   state_next = ST_SINGLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (used_reg[idx_reg] && running_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg;
                    state_next = ST_EVAL;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            ST_EVAL:
            begin
                cnt_waddr = idx_reg;
                if (rd_count_reg != '0)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = rd_count_reg - COUNT_WIDTH'(1);
                    advance   = 1'b1;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // previous expiry goes out; this one is held until the
                    // sweep knows whether it is the final one
                    emit_en         = pend_valid_reg;
                    emit_kind       = KIND_EXPIRED;
                    emit_slot       = pend_slot_reg;
                    emit_tag        = pend_tag_reg;
                    emit_last       = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_slot_next  = SLOT_W'(idx_reg);
                    pend_tag_next   = rd_tag_reg;
                    if (repeat_reg[idx_reg])
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = rd_reload_reg;
                    end
                    else
                    begin
                        running_next[idx_reg] = 1'b0;
                    end
                    advance = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    emit_en = 1'b1;
                    if (pend_valid_reg)
                    begin
                        emit_kind = KIND_EXPIRED;
                        emit_slot = pend_slot_reg;
                        emit_tag  = pend_tag_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                if (out_free)
                begin
                    emit_en = 1'b1;
                    if (free_found)
                    begin
                        alloc_we               = 1'b1;
                        cnt_we                 = 1'b1;
                        cnt_waddr              = free_idx;
                        cnt_wdata              = sat_count;
                        used_next[free_idx]    = 1'b1;
                        running_next[free_idx] = 1'b0;
                        repeat_next[free_idx]  = 1'b0;
                        emit_kind              = KIND_ALLOCATED;
                        emit_slot              = SLOT_W'(free_idx);
                    end
                    else
                    begin
                        emit_kind = KIND_FULL;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SINGLE:
            begin
                if (out_free)
                begin
                    emit_en    = 1'b1;
                    emit_slot  = cur_item_reg.slot;
                    emit_kind  = KIND_NOT_ALLOC;
                    state_next = ST_IDLE;
                    if (slot_ok)
                    begin
                        if (cur_item_reg.op == CMD_REPEAT)
                        begin
                            repeat_next[slot_idx] = cur_item_reg.rep;
                            emit_kind             = KIND_MODE_SET;
                        end
                        else if (slot_run)
                        begin
                            emit_kind = KIND_RUNNING;
                        end
                        else
                        begin
                            running_next[slot_idx] = 1'b1;
                            emit_kind              = KIND_STARTED;
                        end
                    end
                end
            end
            ST_STOP_RD:
            begin
                rd_en      = slot_ok;
                state_next = ST_STOP_WR;
            end
            ST_STOP_WR:
            begin
                if (out_free)
                begin
                    emit_en    = 1'b1;
                    emit_slot  = cur_item_reg.slot;
                    emit_kind  = KIND_NOT_ALLOC;
                    state_next = ST_IDLE;
                    if (slot_ok)
                    begin
                        cnt_we                 = 1'b1;
                        running_next[slot_idx] = 1'b0;
                        repeat_next[slot_idx]  = 1'b0;
                        emit_kind              = KIND_STOPPED;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance)
        begin
            if (idx_reg == LAST_IDX)
            begin
                state_next = ST_FLUSH;
            end
            else
            begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = ST_SCAN;
            end
        end
    end

    assign out_valid_next = emit_en || (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (alloc_we)
        begin
            reload_mem[free_idx] <= sat_count;
            tag_mem[free_idx]    <= cur_item_reg.tag;
        end
        if (rd_en)
        begin
            rd_count_reg  <= count_mem[rd_addr];
            rd_reload_reg <= reload_mem[rd_addr];
            rd_tag_reg    <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        cur_item_reg  <= cur_item_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        if (emit_en)
        begin
            out_kind_reg <= emit_kind;
            out_slot_reg <= emit_slot;
            out_tag_reg  <= emit_tag;
            out_last_reg <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            used_reg       <= '0;
            running_reg    <= '0;
            repeat_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            used_reg       <= used_next;
            running_reg    <= running_next;
            repeat_reg     <= repeat_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign slot_out  = out_slot_reg;
    assign tag_out   = out_tag_reg;
    assign last      = out_last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |-> out_free)
        else $error("result loaded over an untaken transfer");

    a_run_used: assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg & ~used_reg) == '0)
        else $error("running flag on a free slot");

    a_rep_used: assert property (@(posedge clk) disable iff (!rst_n)
        (repeat_reg & ~used_reg) == '0)
        else $error("repeat flag on a free slot");

    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_EVAL
                            || state_reg == ST_FLUSH))
        else $error("held expiry outside a tick sweep");

    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg != ST_IDLE)
        else $error("command popped but not started");

endmodule

// ===== rtl/timer_bank_with_auto_reload_top.sv =====
// Top level of the timer bank with auto-reload: command queue front end
// and slot execution back end. Depends on tbk_pkg, tbk_front, tbk_back.
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_stall  | cmd, slot, count_setting, tag, repeat_req
//   result  | out       | out_valid/out_stall| kind, slot_out, tag_out, last
//
// A two-entry queue sits between intake and execution; unknown commands
// are dropped at intake. Allocate, start and set repeat each run in one state;
// stop reads the slot, then reloads its count. A tick sweeps the slots in order
// through the count memory port, reading and then evaluating each running slot.
// Result stalls hold the sweep only when an expiry or the closing result must leave.
// Reset clears flags and control; count, reload and tag memories are not cleared.
module timer_bank_with_auto_reload_top
    import tbk_pkg::*;
#(
    parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [SLOT_W-1:0]    slot,
    input  logic [SETTING_W-1:0] count_setting,
    input  logic [TAG_W-1:0]     tag,
    input  logic                 repeat_req,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KIND_W-1:0]    kind,
    output logic [SLOT_W-1:0]    slot_out,
    output logic [TAG_W-1:0]     tag_out,
    output logic                 last
);

    logic      q_valid;
    logic      q_pop;
    cmd_item_t q_item;

    tbk_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .slot          (slot),
        .count_setting (count_setting),
        .tag           (tag),
        .repeat_req    (repeat_req),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    tbk_back #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .slot_out  (slot_out),
        .tag_out   (tag_out),
        .last      (last)
    );

endmodule
